@@ hw/rtl/lc3_pkg.sv @@
`default_nettype none
package lc3_pkg;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_EXEC    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_LOADED    = 3'd0,
    ST_RESTARTED = 3'd1,
    ST_EXECUTED  = 3'd2,
    ST_SHOW      = 3'd3,
    ST_HALT      = 3'd4,
    ST_UNDEF     = 3'd5,
    ST_PRIV      = 3'd6,
    ST_STOPPED   = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    OPC_BR   = 4'h0,
    OPC_ADD  = 4'h1,
    OPC_LD   = 4'h2,
    OPC_ST   = 4'h3,
    OPC_JSR  = 4'h4,
    OPC_AND  = 4'h5,
    OPC_LDR  = 4'h6,
    OPC_STR  = 4'h7,
    OPC_RTI  = 4'h8,
    OPC_NOT  = 4'h9,
    OPC_LDI  = 4'hA,
    OPC_STI  = 4'hB,
    OPC_JMP  = 4'hC,
    OPC_RES  = 4'hD,
    OPC_LEA  = 4'hE,
    OPC_TRAP = 4'hF
  } opcode_e;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_FETCH,
    FS_RD1,
    FS_RD2,
    FS_DONE
  } fsm_e;

  localparam logic [15:0] StartPcReset = 16'h3000;
  localparam logic [15:0] MemResetWord = 16'hDDDD;
  localparam logic [7:0]  TrapOut      = 8'h67;
  localparam logic [7:0]  TrapHalt     = 8'h25;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] load_address;
    logic [15:0] load_data;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] fetch_pc;
    logic [15:0] instruction;
    logic        reg_write;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        mem_write;
    logic [15:0] mem_address;
    logic [15:0] mem_value;
    logic [2:0]  cond_codes;
    logic [15:0] next_pc;
  } out_t;

  function automatic logic [15:0] sext(input logic [15:0] v, input int unsigned bits);
    logic [15:0] r;
    r = v;
    for (int i = 0; i < 16; i++) begin
      if (i >= bits) r[i] = v[bits-1];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/lc3_instruction_executor.sv @@
`default_nettype none
// lc3 core with its own single-port word memory. each transaction on the
// input channel gives one result. op 0 stores a word and op 2 restarts the
// core at start_pc; both pass through the done state, as do op 3 and op 1
// on a stopped core. op 1 fetches and executes one instruction:
//   register ops, st and str finish in the fetch state;
//   ld, ldr, sti and a trap vector add one memory access (rd1);
//   ldi and rti read memory twice after the fetch (rd1, rd2).
// every access goes through the one memory port, which sets the rate.
// memory words read 0xdddd until written: on reset a clearing pass over all
// MEM_WORDS words runs before the first transaction is taken. the result
// sits in an output register. the next transaction is taken in the cycle
// that result is accepted, so a stalled output holds off the input.
module lc3_instruction_executor
  import lc3_pkg::*;
#(
  parameter int unsigned MEM_WORDS = 65536
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [15:0] mem_q [MEM_WORDS];
  logic [15:0] rdata_q;

  logic        mem_we, mem_re;
  logic [15:0] mem_addr, mem_wdata;

  fsm_e        fs_q, fs_d;
  logic        clr_q;
  logic [AW:0] clr_cnt_q;
  logic [15:0] start_pc_q, pc_q, pc_d, psr_q, psr_d;
  logic [15:0] rf_q [8];
  logic [15:0] rf_wdata;
  logic [2:0]  rf_widx;
  logic        rf_we;
  logic        stop_q, stop_d;
  logic [15:0] ir_q, ir_d, a_q, a_d, t_q, t_d;
  out_t        res_q, res_d;
  logic        ov_q, ov_d;

  // memory, one port
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_cnt_q[AW-1:0]] <= MemResetWord;
    end else if (mem_we) begin
      mem_q[mem_addr[AW-1:0]] <= mem_wdata;
    end else if (mem_re) begin
      rdata_q <= mem_q[mem_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == (AW+1)'(MEM_WORDS - 1)) clr_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pc_q <= StartPcReset;
    end else if (cfg_we_i) begin
      start_pc_q <= cfg_wdata_i;
    end
  end

  logic        accept;
  logic [3:0]  opc;
  logic [2:0]  dr;
  logic [15:0] alu;

  assign in_ready_o = !clr_q && (fs_q == FS_IDLE) && !(ov_q && !out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

  // decode from the instruction register
  assign opc = ir_q[15:12];
  assign dr  = ir_q[11:9];

  function automatic logic [2:0] cc(input logic [15:0] v);
    return v[15] ? 3'b100 : (v == 16'd0 ? 3'b010 : 3'b001);
  endfunction

  always_comb begin
    fs_d = fs_q;  pc_d = pc_q; psr_d = psr_q; stop_d = stop_q;
    ir_d = ir_q;  a_d = a_q;   t_d = t_q;
    res_d = res_q; ov_d = ov_q && !out_ready_i;
    mem_we = 1'b0; mem_re = 1'b0; mem_addr = '0; mem_wdata = '0;
    rf_we = 1'b0; rf_widx = '0; rf_wdata = '0;
    alu = '0;

    case (fs_q)
      FS_IDLE: begin
        if (accept) begin
          res_d = '0;
          res_d.fetch_pc = pc_q;
          res_d.status = ST_STOPPED;
          case (in_data_i.op)
            OP_LOAD: begin
              mem_we = 1'b1; mem_addr = in_data_i.load_address;
              mem_wdata = in_data_i.load_data;
              res_d.status = ST_LOADED; res_d.mem_write = 1'b1;
              res_d.mem_address = in_data_i.load_address;
              res_d.mem_value = in_data_i.load_data;
              fs_d = FS_DONE;
            end
            OP_RESTART: begin
              psr_d = '0; pc_d = start_pc_q; stop_d = 1'b0;
              res_d.status = ST_RESTARTED;
              fs_d = FS_DONE;
            end
            OP_EXEC: begin
              if (stop_q) begin
                fs_d = FS_DONE;
              end else begin
                mem_re = 1'b1; mem_addr = pc_q;
                fs_d = FS_FETCH;
              end
            end
            default: fs_d = FS_DONE;
          endcase
        end
      end

      FS_FETCH: begin
        ir_d = rdata_q;
        fs_d = FS_IDLE;
        ov_d = 1'b1;
        res_d.instruction = rdata_q;
        res_d.status = ST_EXECUTED;
        pc_d = pc_q + 16'd1;
        // pc_q still holds fetch pc here; decode on rdata_q directly
        begin
          logic [15:0] in;
          logic [15:0] p;
          in = rdata_q;
          p = pc_q + 16'd1;
          case (opcode_e'(in[15:12]))
            OPC_BR: begin
              if (|(psr_q[2:0] & in[11:9])) pc_d = p + sext(in, 9);
            end
            OPC_ADD, OPC_AND: begin
              alu = in[5] ? sext(in, 5) : rf_q[in[2:0]];
              alu = (in[15:12] == OPC_ADD) ? rf_q[in[8:6]] + alu : rf_q[in[8:6]] & alu;
              rf_we = 1'b1; rf_widx = in[11:9]; rf_wdata = alu;
              psr_d = {psr_q[15], 12'd0, cc(alu)};
            end
            OPC_NOT: begin
              alu = ~rf_q[in[8:6]];
              rf_we = 1'b1; rf_widx = in[11:9]; rf_wdata = alu;
              psr_d = {psr_q[15], 12'd0, cc(alu)};
            end
            OPC_LEA: begin
              alu = p + sext(in, 9);
              rf_we = 1'b1; rf_widx = in[11:9]; rf_wdata = alu;
              psr_d = {psr_q[15], 12'd0, cc(alu)};
            end
            OPC_JSR: begin
              rf_we = 1'b1; rf_widx = 3'd7; rf_wdata = p;
              pc_d = in[11] ? p + sext(in, 11) : rf_q[in[8:6]];
            end
            OPC_JMP: pc_d = rf_q[in[8:6]];
            OPC_RES: begin
              res_d.status = ST_UNDEF; stop_d = 1'b1;
            end
            OPC_ST, OPC_STR: begin
              alu = (in[15:12] == OPC_ST) ? p + sext(in, 9) : rf_q[in[8:6]] + sext(in, 6);
              mem_we = 1'b1; mem_addr = alu; mem_wdata = rf_q[in[11:9]];
              res_d.mem_write = 1'b1; res_d.mem_address = alu;
              res_d.mem_value = rf_q[in[11:9]];
            end
            OPC_LD, OPC_LDI, OPC_STI: begin
              mem_re = 1'b1; mem_addr = p + sext(in, 9);
              fs_d = FS_RD1; ov_d = ov_q && !out_ready_i;
            end
            OPC_LDR: begin
              mem_re = 1'b1; mem_addr = rf_q[in[8:6]] + sext(in, 6);
              fs_d = FS_RD1; ov_d = ov_q && !out_ready_i;
            end
            OPC_RTI: begin
              if (psr_q[15]) begin
                res_d.status = ST_PRIV; stop_d = 1'b1;
              end else begin
                mem_re = 1'b1; mem_addr = rf_q[6];
                a_d = rf_q[6] + 16'd1;
                fs_d = FS_RD1; ov_d = ov_q && !out_ready_i;
              end
            end
            default: begin
              if (in[7:0] == TrapOut) begin
                res_d.status = ST_SHOW; res_d.reg_value = rf_q[0];
              end else if (in[7:0] == TrapHalt) begin
                res_d.status = ST_HALT; stop_d = 1'b1;
              end else begin
                rf_we = 1'b1; rf_widx = 3'd7; rf_wdata = p;
                mem_re = 1'b1; mem_addr = {8'd0, in[7:0]};
                fs_d = FS_RD1; ov_d = ov_q && !out_ready_i;
              end
            end
          endcase
          if (rf_we) begin
            res_d.reg_write = 1'b1; res_d.reg_index = rf_widx;
            res_d.reg_value = rf_wdata;
          end
        end
      end

      FS_RD1: begin
        case (opcode_e'(opc))
          OPC_LD, OPC_LDR: begin
            rf_we = 1'b1; rf_widx = dr; rf_wdata = rdata_q;
            psr_d = {psr_q[15], 12'd0, cc(rdata_q)};
            fs_d = FS_IDLE; ov_d = 1'b1;
          end
          OPC_LDI: begin
            mem_re = 1'b1; mem_addr = rdata_q; fs_d = FS_RD2;
          end
          OPC_STI: begin
            mem_we = 1'b1; mem_addr = rdata_q; mem_wdata = rf_q[dr];
            res_d.mem_write = 1'b1; res_d.mem_address = rdata_q;
            res_d.mem_value = rf_q[dr];
            fs_d = FS_IDLE; ov_d = 1'b1;
          end
          OPC_RTI: begin
            t_d = rdata_q;
            mem_re = 1'b1; mem_addr = a_q; a_d = a_q + 16'd1; fs_d = FS_RD2;
          end
          default: begin
            pc_d = rdata_q; fs_d = FS_IDLE; ov_d = 1'b1;
          end
        endcase
        if (rf_we) begin
          res_d.reg_write = 1'b1; res_d.reg_index = rf_widx;
          res_d.reg_value = rf_wdata;
        end
      end

      FS_RD2: begin
        rf_we = 1'b1; fs_d = FS_IDLE; ov_d = 1'b1;
        if (opc == OPC_RTI) begin
          pc_d = t_q; psr_d = rdata_q;
          rf_widx = 3'd6; rf_wdata = a_q;
        end else begin
          rf_widx = dr; rf_wdata = rdata_q;
          psr_d = {psr_q[15], 12'd0, cc(rdata_q)};
        end
        res_d.reg_write = 1'b1; res_d.reg_index = rf_widx;
        res_d.reg_value = rf_wdata;
      end

      FS_DONE: begin
        fs_d = FS_IDLE; ov_d = 1'b1;
      end

      default: fs_d = FS_IDLE;
    endcase

    if (ov_d && !(ov_q && !out_ready_i)) begin
      res_d.cond_codes = psr_d[2:0];
      res_d.next_pc = pc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q   <= FS_IDLE;
      pc_q   <= StartPcReset;
      psr_q  <= '0;
      stop_q <= 1'b0;
      ov_q   <= 1'b0;
      for (int i = 0; i < 8; i++) rf_q[i] <= '0;
    end else begin
      fs_q   <= fs_d;
      pc_q   <= pc_d;
      psr_q  <= psr_d;
      stop_q <= stop_d;
      ov_q   <= ov_d;
      if (fs_q == FS_IDLE && accept && in_data_i.op == OP_RESTART) begin
        for (int i = 0; i < 8; i++) rf_q[i] <= '0;
      end else if (rf_we) begin
        rf_q[rf_widx] <= rf_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ir_q  <= ir_d;
    a_q   <= a_d;
    t_q   <= t_d;
    res_q <= res_d;
  end

endmodule
`default_nettype wire
